>>> rtl/slcs_pkg.sv
package slcs_pkg;

  localparam int unsigned LineBitsDefault = 16;
  localparam int unsigned LineOutW        = 16;
  localparam int unsigned QueueDepth      = 2;

  typedef enum logic [3:0] {
    ST_WS, ST_ID, ST_INT, ST_DBL, ST_STR, ST_OP, ST_LOG, ST_INC, ST_CMP,
    ST_PSO, ST_PD, ST_ESC, ST_COM, ST_BLK
  } state_e;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_ERROR = 2'd2
  } res_kind_e;

  localparam logic [3:0] TK_IDENT    = 4'd0;
  localparam logic [3:0] TK_INT      = 4'd1;
  localparam logic [3:0] TK_DOUBLE   = 4'd2;
  localparam logic [3:0] TK_STRING   = 4'd3;
  localparam logic [3:0] TK_OP       = 4'd4;
  localparam logic [3:0] TK_LOGIC    = 4'd5;
  localparam logic [3:0] TK_INCDEC   = 4'd6;
  localparam logic [3:0] TK_COMPOUND = 4'd7;
  localparam logic [3:0] TK_ARITH    = 4'd8;
  localparam logic [3:0] TK_STR_ESC  = 4'd9;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [7:0]          out_char;
    logic [3:0]          token_kind;
    logic [LineOutW-1:0] line_number;
    logic                last_of_run;
  } out_item_t;

  // Everything one input item produces: leading close, character, trailing close
  typedef struct packed {
    logic [LineOutW-1:0] line_number;
    logic                pre_v;
    logic [3:0]          pre_tk;
    logic                ch_v;
    logic                ch_err;
    logic [7:0]          ch;
    logic                post_v;
    logic [3:0]          post_tk;
  } bundle_t;

endpackage

>>> rtl/slcs_front.sv
module slcs_front import slcs_pkg::*; #(
  parameter int unsigned LINE_BITS = LineBitsDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  in_item_t in_item_i,
  input  logic     q_full_i,
  output logic     bundle_push_o,
  output bundle_t  bundle_o
);

  typedef struct packed {
    state_e     st;
    logic       ld;
    logic       ch_done;
    logic       ch_v;
    logic [7:0] ch;
    logic       pre_v;
    logic [3:0] pre_tk;
    logic       post_v;
    logic [3:0] post_tk;
  } lex_work_t;

  state_e               state_q, state_d;
  logic                 lone_dot_q, lone_dot_d;
  logic                 err_q, err_d;
  logic [LINE_BITS-1:0] line_q, line_d;
  lex_work_t            w;
  logic                 bad;
  logic                 take;
  logic [7:0]           c;

  function automatic lex_work_t do_close(lex_work_t wi);
    lex_work_t  wo;
    logic       v;
    logic [3:0] tk;
    wo = wi;
    v  = 1'b1;
    tk = TK_IDENT;
    case (wi.st)
      ST_ID:   tk = TK_IDENT;
      ST_INT:  tk = TK_INT;
      ST_DBL:  tk = TK_DOUBLE;
      ST_STR:  tk = TK_STRING;
      ST_OP:   tk = TK_OP;
      ST_LOG:  tk = TK_LOGIC;
      ST_INC:  tk = TK_INCDEC;
      ST_CMP:  tk = TK_COMPOUND;
      ST_PSO:  tk = TK_ARITH;
      ST_ESC:  tk = TK_STR_ESC;
      ST_PD:   tk = wi.ld ? TK_OP : TK_DOUBLE;
      default: v = 1'b0;
    endcase
    if (v) begin
      if (wi.ch_done) begin
        wo.post_v  = 1'b1;
        wo.post_tk = tk;
      end else begin
        wo.pre_v  = 1'b1;
        wo.pre_tk = tk;
      end
    end
    wo.st = ST_WS;
    wo.ld = 1'b0;
    return wo;
  endfunction

  function automatic lex_work_t do_append(lex_work_t wi, logic [7:0] ch);
    lex_work_t wo;
    wo = wi;
    if (wi.st == ST_PD) wo.ld = 1'b0;
    wo.ch_done = 1'b1;
    wo.ch_v    = (wi.st != ST_COM) && (wi.st != ST_BLK);
    wo.ch      = ch;
    return wo;
  endfunction

  function automatic lex_work_t do_single(lex_work_t wi, logic [7:0] ch);
    lex_work_t wo;
    wo    = do_close(wi);
    wo.st = ST_OP;
    wo    = do_append(wo, ch);
    wo    = do_close(wo);
    return wo;
  endfunction

  function automatic logic in_scb(state_e s);
    return (s == ST_STR) || (s == ST_COM) || (s == ST_BLK);
  endfunction

  assign c    = in_item_i.in_char;
  assign take = push_i && !q_full_i && !err_q;

  always_comb begin
    w         = '0;
    w.st      = state_q;
    w.ld      = lone_dot_q;
    bad       = 1'b0;
    err_d     = err_q;
    line_d    = line_q;
    if (in_item_i.end_of_text) begin
      w      = do_close(w);
      line_d = LINE_BITS'(1);
    end else if (w.st == ST_ESC) begin
      case (c)
        CH_LC_N: begin
          w.st = ST_STR;
          w    = do_append(w, CH_LF);
        end
        CH_LC_R: begin
          w.st = ST_STR;
          w    = do_append(w, CH_CR);
        end
        CH_LC_T: begin
          w.st = ST_STR;
          w    = do_append(w, CH_TAB);
        end
        CH_BSLASH: begin
          w.st = ST_STR;
          w    = do_append(w, CH_BSLASH);
        end
        default: begin
          bad   = 1'b1;
          err_d = 1'b1;
        end
      endcase
    end else if (c >= CH_0 && c <= CH_9) begin
      if (w.st == ST_PSO) begin
        w.st = ST_OP;
        w    = do_close(w);
        w.st = ST_INT;
      end else if (w.st == ST_WS) begin
        w.st = ST_INT;
      end else if (w.st == ST_PD) begin
        w.st = ST_DBL;
      end else if (w.st == ST_OP || w.st == ST_LOG) begin
        w    = do_close(w);
        w.st = ST_INT;
      end
      w = do_append(w, c);
    end else begin
      case (c)
        CH_DOT: begin
          if (w.st == ST_WS) begin
            w.st = ST_PD;
            w    = do_append(w, c);
            w.ld = 1'b1;
          end else if (w.st == ST_INT) begin
            w.st = ST_DBL;
            w    = do_append(w, c);
          end else if (in_scb(w.st)) begin
            w = do_append(w, c);
          end else begin
            w = do_single(w, c);
          end
        end
        CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN,
        CH_SEMI, CH_COMMA, CH_LBRACK, CH_RBRACK: begin
          if (w.st == ST_PSO) w.st = ST_OP;
          if (in_scb(w.st)) w = do_append(w, c);
          else              w = do_single(w, c);
        end
        CH_PLUS, CH_MINUS: begin
          if (w.st == ST_PSO) begin
            w.st = ST_INC;
            w    = do_append(w, c);
            w    = do_close(w);
          end else if (!in_scb(w.st)) begin
            w    = do_close(w);
            w.st = ST_PSO;
            w    = do_append(w, c);
          end else begin
            w = do_append(w, c);
          end
        end
        CH_STAR, CH_SLASH, CH_PCT: begin
          if (!in_scb(w.st)) begin
            w    = do_close(w);
            w.st = ST_PSO;
          end
          w = do_append(w, c);
        end
        CH_EQ: begin
          if (w.st == ST_LOG || w.st == ST_OP) begin
            w.st = ST_LOG;
            w    = do_append(w, c);
            w    = do_close(w);
          end else if (w.st == ST_PSO) begin
            w.st = ST_CMP;
            w    = do_append(w, c);
            w    = do_close(w);
          end else if (!in_scb(w.st)) begin
            w    = do_close(w);
            w.st = ST_OP;
            w    = do_append(w, c);
          end else begin
            w = do_append(w, c);
          end
        end
        CH_LT, CH_GT, CH_BANG: begin
          if (!in_scb(w.st)) begin
            w    = do_close(w);
            w.st = ST_LOG;
          end
          w = do_append(w, c);
        end
        CH_SPACE, CH_TAB: begin
          if (in_scb(w.st)) begin
            w = do_append(w, c);
          end else begin
            if (w.st == ST_PSO) w.st = ST_OP;
            w = do_close(w);
          end
        end
        CH_CR, CH_LF: begin
          if (w.st == ST_BLK) begin
            w = do_append(w, c);
          end else begin
            if (w.st == ST_PSO) w.st = ST_OP;
            w = do_close(w);
          end
          if (line_q != '1) line_d = line_q + LINE_BITS'(1);
        end
        CH_DQUOTE: begin
          if (!in_scb(w.st)) begin
            w    = do_close(w);
            w.st = ST_STR;
          end else if (w.st == ST_STR) begin
            w = do_close(w);
          end
        end
        CH_BSLASH: begin
          if (w.st == ST_STR) begin
            w.st = ST_ESC;
          end else if (w.st == ST_COM || w.st == ST_BLK) begin
            w = do_append(w, c);
          end else begin
            if (w.st == ST_PSO) w.st = ST_OP;
            w = do_single(w, c);
          end
        end
        CH_HASH: begin
          if (w.st == ST_STR || w.st == ST_BLK) begin
            w = do_append(w, c);
          end else begin
            if (w.st == ST_PSO) w.st = ST_OP;
            w    = do_close(w);
            w.st = ST_COM;
            w    = do_append(w, c);
          end
        end
        CH_PIPE: begin
          if (w.st == ST_STR) begin
            w = do_append(w, c);
          end else if (w.st == ST_BLK) begin
            w = do_append(w, c);
            w = do_close(w);
          end else begin
            if (w.st == ST_PSO) w.st = ST_OP;
            w    = do_close(w);
            w.st = ST_BLK;
            w    = do_append(w, c);
          end
        end
        default: begin
          if (w.st == ST_WS || w.st == ST_INT || w.st == ST_DBL ||
              w.st == ST_OP || w.st == ST_LOG || w.st == ST_PSO) begin
            if (w.st == ST_PSO) w.st = ST_OP;
            w    = do_close(w);
            w.st = ST_ID;
          end
          w = do_append(w, c);
        end
      endcase
    end
    state_d    = w.st;
    lone_dot_d = w.ld;
  end

  // bad escape: a lone error result; the state stays put as nothing follows it
  always_comb begin
    bundle_o             = '0;
    bundle_o.line_number = LineOutW'(line_q);
    if (bad) begin
      bundle_o.ch_v   = 1'b1;
      bundle_o.ch_err = 1'b1;
      bundle_o.ch     = c;
    end else begin
      bundle_o.pre_v   = w.pre_v;
      bundle_o.pre_tk  = w.pre_tk;
      bundle_o.ch_v    = w.ch_v;
      bundle_o.ch      = w.ch;
      bundle_o.post_v  = w.post_v;
      bundle_o.post_tk = w.post_tk;
    end
  end

  assign bundle_push_o = take && (bundle_o.pre_v || bundle_o.ch_v || bundle_o.post_v);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_WS;
      lone_dot_q <= 1'b0;
      err_q      <= 1'b0;
      line_q     <= LINE_BITS'(1);
    end else if (take) begin
      err_q <= err_d;
      if (!bad) begin
        state_q    <= state_d;
        lone_dot_q <= lone_dot_d;
        line_q     <= line_d;
      end
    end
  end

endmodule

>>> rtl/slcs_queue.sv
module slcs_queue import slcs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    wr_i,
  input  bundle_t wr_data_i,
  input  logic    rd_i,
  output bundle_t rd_data_o,
  output logic    full_o,
  output logic    empty_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  bundle_t             mem_q [QueueDepth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;
  logic                do_wr, do_rd;

  assign full_o    = (count_q == CntW'(QueueDepth));
  assign empty_o   = (count_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_wr && !do_rd)      count_q <= count_q + CntW'(1);
      else if (do_rd && !do_wr) count_q <= count_q - CntW'(1);
    end
  end

endmodule

>>> rtl/slcs_back.sv
module slcs_back import slcs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  bundle_t   head_i,
  input  logic      q_empty_i,
  output logic      q_pop_o,
  output logic      empty_o,
  input  logic      pop_i,
  output out_item_t out_item_o
);

  out_item_t  out_q, out_d;
  logic       out_valid_q;
  logic [2:0] sent_q, sent_d;
  logic [2:0] rem, pick, left;
  logic       load;

  // slot 0 leading close, slot 1 character, slot 2 trailing close
  assign rem  = {head_i.post_v, head_i.ch_v, head_i.pre_v} & ~sent_q;
  assign pick = rem[0] ? 3'b001 : (rem[1] ? 3'b010 : 3'b100);
  assign left = rem & ~pick;
  assign load = !q_empty_i && (!out_valid_q || pop_i);

  always_comb begin
    out_d             = '0;
    out_d.line_number = head_i.line_number;
    out_d.last_of_run = (left == '0);
    if (pick[0]) begin
      out_d.kind       = KIND_CLOSE;
      out_d.token_kind = head_i.pre_tk;
    end else if (pick[1]) begin
      out_d.kind     = head_i.ch_err ? KIND_ERROR : KIND_CHAR;
      out_d.out_char = head_i.ch;
    end else begin
      out_d.kind       = KIND_CLOSE;
      out_d.token_kind = head_i.post_tk;
    end
    sent_d = sent_q;
    if (load) sent_d = (left == '0) ? '0 : (sent_q | pick);
  end

  assign q_pop_o    = load && (left == '0);
  assign empty_o    = !out_valid_q;
  assign out_item_o = out_q;

  always_ff @(posedge clk_i) begin
    if (load) out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sent_q      <= '0;
    end else begin
      sent_q <= sent_d;
      if (load)       out_valid_q <= 1'b1;
      else if (pop_i) out_valid_q <= 1'b0;
    end
  end

endmodule

>>> rtl/source_lexer_char_stream.sv
// Path: the first result of an item passes through the bundle queue and then the result register.
// Throughput: one item per cycle at the input while the two-entry bundle queue has room and
// no bad escape has set the error flag; results move one per cycle while they are popped,
// and the result register, which an item with several results holds, sets the sustained rate.
// Reset (rst_ni low, asynchronous): lexer at whitespace, line 1, error flag clear, all
// queues empty.
module source_lexer_char_stream import slcs_pkg::*; #(
  parameter int unsigned LINE_BITS = LineBitsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  output logic      full_o,
  input  in_item_t  in_item_i,
  output logic      empty_o,
  input  logic      pop_i,
  output out_item_t out_item_o
);

  bundle_t front_bundle, head_bundle;
  logic    front_push, q_full, q_empty, q_pop;

  assign full_o = q_full;

  slcs_front #(
    .LINE_BITS (LINE_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push_i),
    .in_item_i     (in_item_i),
    .q_full_i      (q_full),
    .bundle_push_o (front_push),
    .bundle_o      (front_bundle)
  );

  slcs_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (front_push),
    .wr_data_i (front_bundle),
    .rd_i      (q_pop),
    .rd_data_o (head_bundle),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  slcs_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head_bundle),
    .q_empty_i  (q_empty),
    .q_pop_o    (q_pop),
    .empty_o    (empty_o),
    .pop_i      (pop_i),
    .out_item_o (out_item_o)
  );

endmodule
